FILE: rtl/core/ultrasonic_echo_ranger_macros.svh
// ----------------------------------------------------------------------------
// ultrasonic echo ranger assertion macros
// immediate-implication and next-cycle checks, compiled out under SYNTH
// ----------------------------------------------------------------------------
`ifndef ULTRASONIC_ECHO_RANGER_MACROS_SVH
`define ULTRASONIC_ECHO_RANGER_MACROS_SVH

`ifndef SYNTH
`define UER_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("uer assertion failed: implication");
`define UER_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("uer assertion failed: next cycle");
`else
`define UER_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define UER_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

FILE: rtl/core/uer_pkg.sv
// ----------------------------------------------------------------------------
// uer_pkg
// shared constants and types for the echo ranger
// ----------------------------------------------------------------------------
`default_nettype none

package uer_pkg;

    localparam int HISTORY_DEPTH = 8;
    localparam int HIST_IDX_W    = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

    localparam int TRIG_W   = 10;
    localparam int TOUT_W   = 16;
    localparam int CAP_W    = 16;
    localparam int GAP_W    = 20;
    localparam int TIMER_W  = 20;
    localparam int VALUE_W  = 16;
    localparam int SEQ_W    = 32;
    localparam int RD_IDX_W = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_TICKS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WAIT_TIMEOUT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ECHO_CAP      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAP_TICKS     = 2'd3;

    localparam logic [TRIG_W-1:0] TRIGGER_RESET = 10'd10;
    localparam logic [TOUT_W-1:0] TIMEOUT_RESET = 16'd38000;
    localparam logic [CAP_W-1:0]  CAP_RESET     = 16'd38000;
    localparam logic [GAP_W-1:0]  GAP_RESET     = 20'd60000;
    localparam logic [CAP_W-1:0]  CAP_LIMIT     = 16'd65534;

    typedef struct packed {
        logic               trigger_out;
        logic               ready_pulse;
        logic [VALUE_W-1:0] latest_us;
        logic [SEQ_W-1:0]   sequence_count;
    } uer_result_t;

    typedef struct packed {
        logic               wr_en;
        logic [VALUE_W-1:0] data;
    } uer_hist_wr_t;

endpackage

`default_nettype wire

FILE: rtl/core/ultrasonic_echo_ranger.sv
// an accepted request waits in the input register; its result is then registered into the output register
// throughput: one tick request per cycle while m_ready keeps the output free, set by the single-pass sequencer update
// an input register buffers one request while a result waits on the output
// reset: synchronous, active low; trigger phase, counters, latest value and
// history all cleared, configuration back to its defaults
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger
// ultrasonic ranging sequencer with echo width measurement and history ring
// ----------------------------------------------------------------------------
`default_nettype none

module ultrasonic_echo_ranger
    import uer_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic                  s_echo_level,
    input  wire logic [RD_IDX_W-1:0]   s_history_read_index,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic                       m_trigger_out,
    output logic                       m_ready_pulse,
    output logic [VALUE_W-1:0]         m_latest_us,
    output logic [SEQ_W-1:0]           m_sequence_count,
    output logic [VALUE_W-1:0]         m_history_value
);

    logic                in_vld_reg, in_vld_next;
    logic                in_echo_reg;
    logic [RD_IDX_W-1:0] in_idx_reg;
    logic                out_vld_reg, out_vld_next;
    uer_result_t         out_res_reg;
    logic [VALUE_W-1:0]  out_hist_reg;

    logic                take_in;
    logic                load_out;
    uer_result_t         res;
    uer_hist_wr_t        hist_wr;
    logic [VALUE_W-1:0]  hist_data;

    assign load_out = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready  = !in_vld_reg || load_out;
    assign take_in  = s_valid && s_ready;

    always_comb begin
        if (take_in) begin
            in_vld_next = 1'b1;
        end else if (load_out) begin
            in_vld_next = 1'b0;
        end else begin
            in_vld_next = in_vld_reg;
        end
        if (load_out) begin
            out_vld_next = 1'b1;
        end else if (m_ready) begin
            out_vld_next = 1'b0;
        end else begin
            out_vld_next = out_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take_in) begin
            in_echo_reg <= s_echo_level;
            in_idx_reg  <= s_history_read_index;
        end
        if (load_out) begin
            out_res_reg  <= res;
            out_hist_reg <= hist_data;
        end
    end

    uer_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .step      (load_out),
        .echo      (in_echo_reg),
        .result    (res),
        .hist_wr   (hist_wr)
    );

    uer_hist u_hist (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .hist_wr  (hist_wr),
        .rd_index (in_idx_reg),
        .rd_data  (hist_data)
    );

    assign m_valid          = out_vld_reg;
    assign m_trigger_out    = out_res_reg.trigger_out;
    assign m_ready_pulse    = out_res_reg.ready_pulse;
    assign m_latest_us      = out_res_reg.latest_us;
    assign m_sequence_count = out_res_reg.sequence_count;
    assign m_history_value  = out_hist_reg;

endmodule

`default_nettype wire

FILE: rtl/core/uer_hist.sv
// ----------------------------------------------------------------------------
// uer_hist
// history ring of measured echo widths with write-through read port
// ----------------------------------------------------------------------------
`default_nettype none

module uer_hist
    import uer_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire uer_hist_wr_t        hist_wr,
    input  wire logic [RD_IDX_W-1:0] rd_index,
    output logic      [VALUE_W-1:0]  rd_data
);

    localparam int EXT_W = 9;

    logic [VALUE_W-1:0]    ring_reg [HISTORY_DEPTH];
    logic [HIST_IDX_W-1:0] slot_reg;
    logic [HIST_IDX_W-1:0] slot_next;
    logic [EXT_W-1:0]      rd_ext;
    logic [HIST_IDX_W-1:0] rd_sel;

    always_comb begin
        if (slot_reg == HIST_IDX_W'(HISTORY_DEPTH - 1)) begin
            slot_next = '0;
        end else begin
            slot_next = slot_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg <= '0;
            for (int i = 0; i < HISTORY_DEPTH; i++) begin
                ring_reg[i] <= '0;
            end
        end else if (hist_wr.wr_en) begin
            ring_reg[slot_reg] <= hist_wr.data;
            slot_reg           <= slot_next;
        end
    end

    assign rd_ext = EXT_W'(rd_index);
    assign rd_sel = rd_ext[HIST_IDX_W-1:0];

    // result shows the ring after this request's write
    always_comb begin
        if (rd_ext >= EXT_W'(HISTORY_DEPTH)) begin
            rd_data = '0;
        end else if (hist_wr.wr_en && (slot_reg == rd_sel)) begin
            rd_data = hist_wr.data;
        end else begin
            rd_data = ring_reg[rd_sel];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/uer_ctrl.sv
// ----------------------------------------------------------------------------
// uer_ctrl
// measurement sequencer: trigger, echo wait, echo count and gap phases
// ----------------------------------------------------------------------------
`default_nettype none
`include "ultrasonic_echo_ranger_macros.svh"

module uer_ctrl
    import uer_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  step,
    input  wire logic                  echo,
    output uer_result_t                result,
    output uer_hist_wr_t               hist_wr
);

    typedef enum logic [2:0] {
        PH_TRIGGER,
        PH_WAIT,
        PH_COUNT,
        PH_GAP
    } phase_t;

    logic [TRIG_W-1:0]  trig_ticks_reg;
    logic [TOUT_W-1:0]  timeout_reg;
    logic [CAP_W-1:0]   cap_reg;
    logic [GAP_W-1:0]   gap_ticks_reg;

    phase_t             phase_reg, phase_next;
    logic [TIMER_W-1:0] timer_reg, timer_next;
    logic [VALUE_W-1:0] count_reg, count_next;
    logic [VALUE_W-1:0] latest_reg, latest_next;
    logic [SEQ_W-1:0]   attempt_reg, attempt_next;

    logic [CAP_W-1:0]   cap;
    logic [TRIG_W-1:0]  trig_lim;
    logic [GAP_W-1:0]   gap_lim;
    logic [TIMER_W-1:0] timer_inc;
    logic [VALUE_W-1:0] count_inc;
    logic               finish;
    logic               keep;
    logic [VALUE_W-1:0] finish_value;
    logic               trig;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trig_ticks_reg <= TRIGGER_RESET;
            timeout_reg    <= TIMEOUT_RESET;
            cap_reg        <= CAP_RESET;
            gap_ticks_reg  <= GAP_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_TRIGGER_TICKS: trig_ticks_reg <= cfg_wdata[TRIG_W-1:0];
                REG_WAIT_TIMEOUT:  timeout_reg    <= cfg_wdata[TOUT_W-1:0];
                REG_ECHO_CAP:      cap_reg        <= cfg_wdata[CAP_W-1:0];
                REG_GAP_TICKS:     gap_ticks_reg  <= cfg_wdata[GAP_W-1:0];
                default: ;
            endcase
        end
    end

    // cap plus one must still fit the result width
    assign cap       = (cap_reg > CAP_LIMIT) ? CAP_LIMIT : cap_reg;
    assign trig_lim  = (trig_ticks_reg == '0) ? TRIG_W'(1) : trig_ticks_reg;
    assign gap_lim   = (gap_ticks_reg == '0) ? GAP_W'(1) : gap_ticks_reg;
    assign timer_inc = timer_reg + 1'b1;
    assign count_inc = count_reg + 1'b1;

    always_comb begin
        phase_next   = phase_reg;
        timer_next   = timer_reg;
        count_next   = count_reg;
        finish       = 1'b0;
        keep         = 1'b0;
        finish_value = '0;
        trig         = 1'b0;
        case (phase_reg)
            PH_TRIGGER: begin
                trig = 1'b1;
                if (timer_inc >= TIMER_W'(trig_lim)) begin
                    phase_next = PH_WAIT;
                    timer_next = '0;
                end else begin
                    timer_next = timer_inc;
                end
            end
            PH_WAIT: begin
                if (echo) begin
                    count_next = VALUE_W'(1);
                    timer_next = '0;
                    if (cap == '0) begin
                        finish       = 1'b1;
                        keep         = 1'b1;
                        finish_value = VALUE_W'(1);
                    end else begin
                        phase_next = PH_COUNT;
                    end
                end else if (timer_inc > TIMER_W'(timeout_reg)) begin
                    finish = 1'b1;
                end else begin
                    timer_next = timer_inc;
                end
            end
            PH_COUNT: begin
                if (echo) begin
                    count_next = count_inc;
                    if (count_inc > cap) begin
                        finish       = 1'b1;
                        keep         = 1'b1;
                        finish_value = count_inc;
                    end
                end else begin
                    finish       = 1'b1;
                    keep         = 1'b1;
                    finish_value = count_reg;
                end
            end
            default: begin
                if (timer_inc >= TIMER_W'(gap_lim)) begin
                    phase_next = PH_TRIGGER;
                    timer_next = '0;
                end else begin
                    timer_next = timer_inc;
                end
            end
        endcase
        if (finish) begin
            phase_next = PH_GAP;
            timer_next = '0;
        end
    end

    assign latest_next  = finish ? finish_value : latest_reg;
    assign attempt_next = finish ? attempt_reg + 1'b1 : attempt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_TRIGGER;
            timer_reg   <= '0;
            count_reg   <= '0;
            latest_reg  <= '0;
            attempt_reg <= '0;
        end else if (step) begin
            phase_reg   <= phase_next;
            timer_reg   <= timer_next;
            count_reg   <= count_next;
            latest_reg  <= latest_next;
            attempt_reg <= attempt_next;
        end
    end

    assign result.trigger_out    = trig;
    assign result.ready_pulse    = finish;
    assign result.latest_us      = latest_next;
    assign result.sequence_count = attempt_next;

    assign hist_wr.wr_en = step && keep;
    assign hist_wr.data  = finish_value;

    `UER_ASSERT_NEXT(a_seq_on_done, aclk, aresetn, step && finish, attempt_reg == $past(attempt_reg) + 1'b1)
    `UER_ASSERT_NEXT(a_hold_idle, aclk, aresetn, !step, $stable(phase_reg) && $stable(attempt_reg))
    `UER_ASSERT_NEXT(a_trig_exit, aclk, aresetn, step && (phase_reg == PH_TRIGGER), (phase_reg == PH_TRIGGER) || (phase_reg == PH_WAIT))

endmodule

`default_nettype wire
